// ----- rtl/ps2_keyboard_controller_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ps2_keyboard_controller_unit_defines
// assertion macros shared by the ps2 keyboard controller rtl
// ----------------------------------------------------------------------------
`ifndef PS2_KEYBOARD_CONTROLLER_UNIT_DEFINES_SVH
`define PS2_KEYBOARD_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PS2KC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ps2kc assertion failed");
`define PS2KC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("ps2kc assertion failed");
`else
`define PS2KC_ASSERT(lbl, clk, rst, prop)
`define PS2KC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/ps2kc_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2kc_pkg
// types and constants of the ps2 keyboard controller
// ----------------------------------------------------------------------------
package ps2kc_pkg;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [2:0] {
    KIND_READ_DATA   = 3'd0,
    KIND_READ_STATUS = 3'd1,
    KIND_WRITE_DATA  = 3'd2,
    KIND_WRITE_CMD   = 3'd3,
    KIND_PORT1_BYTE  = 3'd4,
    KIND_PORT2_BYTE  = 3'd5
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HAS_SECOND_PORT = 1'd0,
    REG_SELF_TEST_REPLY = 1'd1
  } cfg_reg_t;

  localparam logic [7:0] CMD_READ_CTRL  = 8'h20;
  localparam logic [7:0] CMD_WRITE_CTRL = 8'h60;
  localparam logic [7:0] CMD_SELF_TEST  = 8'hAA;
  localparam logic [7:0] CMD_P1_DISABLE = 8'hAD;
  localparam logic [7:0] CMD_P1_ENABLE  = 8'hAE;
  localparam logic [7:0] CMD_P2_DISABLE = 8'hA7;
  localparam logic [7:0] CMD_P2_ENABLE  = 8'hA8;

  localparam logic [7:0] CTRL_RESET      = 8'h30;
  localparam logic [7:0] CTRL_WRITE_MASK = 8'h77;
  localparam logic [7:0] SELF_TEST_RESET = 8'h55;

  localparam int BIT_IRQ1     = 0;
  localparam int BIT_IRQ2     = 1;
  localparam int BIT_SYS      = 2;
  localparam int BIT_CLK1_OFF = 4;
  localparam int BIT_CLK2_OFF = 5;

  typedef struct packed {
    logic [7:0] read_data;
    logic       to_device_valid;
    logic [7:0] to_device_byte;
    logic       irq_port1;
    logic       irq_port2;
    logic       dropped;
  } result_t;

endpackage

// ----- rtl/ps2kc_ifs.sv -----
// ----------------------------------------------------------------------------
// ps2kc_ifs
// request, result and register write channels of the ps2 keyboard controller
// ----------------------------------------------------------------------------
interface ps2kc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  modport source (output valid, output kind, output data, input ready);
  modport sink (input valid, input kind, input data, output ready);
endinterface

interface ps2kc_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       to_device_valid;
  logic [7:0] to_device_byte;
  logic       irq_port1;
  logic       irq_port2;
  logic       dropped;
  modport source (output valid, output read_data, output to_device_valid,
                  output to_device_byte, output irq_port1, output irq_port2,
                  output dropped, input ready);
  modport sink (input valid, input read_data, input to_device_valid,
                input to_device_byte, input irq_port1, input irq_port2,
                input dropped, output ready);
endinterface

interface ps2kc_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- rtl/ps2_keyboard_controller_unit.sv -----
// ----------------------------------------------------------------------------
// ps2_keyboard_controller_unit
// two-port keyboard controller: host port accesses and device bytes in,
// one result per request out
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | kind, data
//  rsp     | out | valid/ready | read_data, to_device_*, irq_port1/2, dropped
//  cfg     | in  | valid/ready | index, wdata
//
//  one request per cycle unless req.ready is low; its result is registered on accept
//  controller state updates in the accept cycle, so back-to-back requests chain
//  a two-entry output stage (output register plus skid) keeps req.ready high
//  while one result waits; req.ready drops only when both are occupied
//  rst is synchronous and active high; cfg.ready is always high
`include "ps2_keyboard_controller_unit_defines.svh"

module ps2_keyboard_controller_unit
  import ps2kc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ps2kc_req_if.sink   req,
  ps2kc_rsp_if.source rsp,
  ps2kc_cfg_if.sink   cfg
);

  logic       has_second_port;
  logic [7:0] self_test_reply;

  logic [7:0] out_byte, out_byte_next;
  logic       out_full, out_full_next;
  logic       out_from_second, out_from_second_next;
  logic [7:0] control_byte, control_byte_next;
  logic       awaiting_control_write, awaiting_control_write_next;
  logic       last_was_command, last_was_command_next;

  result_t    res;
  result_t    out_reg, skid_reg;
  logic       out_valid, skid_valid;
  logic       req_fire, rsp_fire;
  logic [7:0] status_byte;

  assign req.ready = !skid_valid;
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = out_valid && rsp.ready;

  assign status_byte = {2'b00, out_full && out_from_second, 1'b0, last_was_command,
                        control_byte[BIT_SYS], 1'b0, out_full};

  // controller state update and result for one request
  always_comb begin
    out_byte_next               = out_byte;
    out_full_next               = out_full;
    out_from_second_next        = out_from_second;
    control_byte_next           = control_byte;
    awaiting_control_write_next = awaiting_control_write;
    last_was_command_next       = last_was_command;
    res                         = '0;
    case (kind_t'(req.kind))
      KIND_READ_DATA: begin
        res.read_data = out_byte;
        out_full_next = 1'b0;
      end
      KIND_READ_STATUS: begin
        res.read_data = status_byte;
      end
      KIND_WRITE_DATA: begin
        last_was_command_next = 1'b0;
        if (awaiting_control_write) begin
          control_byte_next           = req.data & CTRL_WRITE_MASK;
          awaiting_control_write_next = 1'b0;
        end else begin
          res.to_device_valid = 1'b1;
          res.to_device_byte  = req.data;
        end
      end
      KIND_WRITE_CMD: begin
        last_was_command_next       = 1'b1;
        awaiting_control_write_next = 1'b0;
        case (req.data)
          CMD_READ_CTRL: begin
            out_byte_next        = control_byte;
            out_full_next        = 1'b1;
            out_from_second_next = 1'b0;
          end
          CMD_WRITE_CTRL: awaiting_control_write_next = 1'b1;
          CMD_SELF_TEST: begin
            out_byte_next        = self_test_reply;
            out_full_next        = 1'b1;
            out_from_second_next = 1'b0;
          end
          CMD_P1_DISABLE: control_byte_next[BIT_CLK1_OFF] = 1'b1;
          CMD_P1_ENABLE:  control_byte_next[BIT_CLK1_OFF] = 1'b0;
          CMD_P2_DISABLE: begin
            if (has_second_port) control_byte_next[BIT_CLK2_OFF] = 1'b1;
          end
          CMD_P2_ENABLE: begin
            if (has_second_port) control_byte_next[BIT_CLK2_OFF] = 1'b0;
          end
          default: ;
        endcase
      end
      KIND_PORT1_BYTE: begin
        if (out_full || control_byte[BIT_CLK1_OFF]) begin
          res.dropped = 1'b1;
        end else begin
          out_byte_next        = req.data;
          out_full_next        = 1'b1;
          out_from_second_next = 1'b0;
        end
      end
      KIND_PORT2_BYTE: begin
        if (!has_second_port || out_full || control_byte[BIT_CLK2_OFF]) begin
          res.dropped = 1'b1;
        end else begin
          out_byte_next        = req.data;
          out_full_next        = 1'b1;
          out_from_second_next = 1'b1;
        end
      end
      default: ;
    endcase
    res.irq_port1 = out_full_next && !out_from_second_next &&
                    control_byte_next[BIT_IRQ1];
    res.irq_port2 = out_full_next && out_from_second_next && has_second_port &&
                    control_byte_next[BIT_IRQ2];
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_byte               <= '0;
      out_full               <= 1'b0;
      out_from_second        <= 1'b0;
      control_byte           <= CTRL_RESET;
      awaiting_control_write <= 1'b0;
      last_was_command       <= 1'b0;
    end else if (req_fire) begin
      out_byte               <= out_byte_next;
      out_full               <= out_full_next;
      out_from_second        <= out_from_second_next;
      control_byte           <= control_byte_next;
      awaiting_control_write <= awaiting_control_write_next;
      last_was_command       <= last_was_command_next;
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      has_second_port <= 1'b1;
      self_test_reply <= SELF_TEST_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_HAS_SECOND_PORT: has_second_port <= cfg.wdata[0];
        REG_SELF_TEST_REPLY: self_test_reply <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || rsp_fire) begin
        out_valid <= skid_valid || req_fire;
        skid_valid <= 1'b0;
      end else if (req_fire) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp_fire) begin
      out_reg <= skid_valid ? skid_reg : res;
    end
    if (req_fire && out_valid && !rsp_fire) begin
      skid_reg <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.read_data       = out_reg.read_data;
  assign rsp.to_device_valid = out_reg.to_device_valid;
  assign rsp.to_device_byte  = out_reg.to_device_byte;
  assign rsp.irq_port1       = out_reg.irq_port1;
  assign rsp.irq_port2       = out_reg.irq_port2;
  assign rsp.dropped         = out_reg.dropped;

  `PS2KC_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> out_valid)
  `PS2KC_ASSERT_ALWAYS(a_ctrl_fixed_bits, clk, rst || (!control_byte[3] && !control_byte[7]))
  `PS2KC_ASSERT(a_pending_after_cmd, clk, rst, awaiting_control_write |-> last_was_command)
  `PS2KC_ASSERT(a_forward_clean, clk, rst,
    (out_valid && out_reg.to_device_valid) |->
      (out_reg.read_data == 8'd0 && !out_reg.dropped))

endmodule
